// ===== hw/rtl/seeded_opcode_permutation_codec_macros.svh =====
// Assertion macros shared by the codec RTL files.
`ifndef SEEDED_OPCODE_PERMUTATION_CODEC_MACROS_SVH
`define SEEDED_OPCODE_PERMUTATION_CODEC_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check a condition in the same cycle as its trigger.
`define SOPC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("codec check failed");
// Check a condition in the cycle after its trigger.
`define SOPC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("codec check failed");
`else
`define SOPC_ASSERT_IMPL(label, ante, cons)
`define SOPC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== hw/rtl/sopc_pkg.sv =====
// Shared types and constants of the opcode permutation codec.
`default_nettype none
package sopc_pkg;

	localparam int FIRST_TABLE_LAST_DEF = 208;
	localparam int SECOND_TABLE_MAX_DEF = 88;

	localparam logic [31:0] LCG_MUL  = 32'h0003_43FD;
	localparam logic [31:0] LCG_ADD  = 32'h0026_9EC3;
	localparam logic [7:0]  EXT_MARK = 8'hD0;
	localparam logic [7:0]  FIX_A    = 8'h12;
	localparam logic [7:0]  FIX_B    = 8'hB1;
	localparam logic [7:0]  TOP_V0   = 8'h4E;
	localparam logic [7:0]  TOP_V1   = 8'h55;
	localparam logic [7:0]  TOP_V2   = 8'h58;
	localparam int          RAND_W   = 15;

	typedef enum logic [1:0] {
		OP_INIT   = 2'd0,
		OP_DECODE = 2'd1,
		OP_ENCODE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		VER_0 = 2'd0,
		VER_1 = 2'd1,
		VER_2 = 2'd2
	} version_t;

	typedef enum logic [0:0] {
		REG_SEED    = 1'd0,
		REG_VERSION = 1'd1
	} reg_index_t;

	typedef enum logic [2:0] {
		ST_NONE      = 3'd0,
		ST_ONE       = 3'd1,
		ST_TWO       = 3'd2,
		ST_BAD_FIRST = 3'd3,
		ST_BAD_SECOND= 3'd4,
		ST_INIT_DONE = 3'd5
	} status_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DRAIN,
		S_FILL,
		S_RAND,
		S_MOD_GO,
		S_MOD_WAIT,
		S_RD_I,
		S_RD_J,
		S_WR_J,
		S_WR_I,
		S_SRCH_RD,
		S_SRCH_CMP,
		S_FIX_RD,
		S_FIX_WK,
		S_FIX_WV,
		S_INV_RD,
		S_INV_WR,
		S_FINISH
	} seq_state_t;

endpackage
`default_nettype wire

// ===== hw/rtl/sopc_in_if.sv =====
// Input channel of the codec: operation and opcode bytes.
`default_nettype none
interface sopc_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] op;
	logic [7:0] first_byte;
	logic [7:0] second_byte;

	modport source(output valid, output op, output first_byte, output second_byte,
		input ready);
	modport sink(input valid, input op, input first_byte, input second_byte,
		output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/sopc_out_if.sv =====
// Output channel of the codec: mapped bytes and status.
`default_nettype none
interface sopc_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] first_out;
	logic [7:0] second_out;
	logic [2:0] status;

	modport source(output valid, output first_out, output second_out, output status,
		input ready);
	modport sink(input valid, input first_out, input second_out, input status,
		output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/sopc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module sopc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and read; read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== hw/rtl/sopc_modulo.sv =====
// Restoring remainder unit: one dividend bit per cycle.
`default_nettype none
`include "seeded_opcode_permutation_codec_macros.svh"
module sopc_modulo import sopc_pkg::*; #(
	parameter int IDXW = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [RAND_W-1:0] dividend,
	input  wire logic [IDXW:0]     divisor,
	output      logic              done,
	output      logic [IDXW-1:0]   rem
);
	localparam int CW = $clog2(RAND_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CW-1:0]     cnt_q;
	logic [RAND_W-1:0] dq_q;
	logic [IDXW-1:0]   rem_q;
	logic [IDXW:0]     trial;
	logic [IDXW:0]     diff;

	// Shift in the next dividend bit and subtract when it fits
	always_comb begin
		trial = {rem_q, dq_q[RAND_W-1]};
		diff  = trial - divisor;
	end

	// Step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(RAND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder datapath
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dq_q  <= {dq_q[RAND_W-2:0], 1'b0};
			rem_q <= (trial >= divisor) ? IDXW'(diff) : IDXW'(trial);
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

	`SOPC_ASSERT_IMPL(a_start_when_free, start, !busy_q)
	`SOPC_ASSERT_IMPL(a_done_after_busy, done_q, !busy_q)
	`SOPC_ASSERT_NEXT(a_start_busy, start, busy_q)
endmodule
`default_nettype wire

// ===== hw/rtl/seeded_opcode_permutation_codec.sv =====
// Seeded opcode permutation codec: the top level.
// Decode and encode items are table lookups: one item is taken per cycle while
// the output is not stalled and no init runs, and its result passes through the
// RAM read and then the output register. An init item (op 0) seeds the
// generator from the seed register, fills both forward tables with the identity,
// Fisher-Yates shuffles table one and then table two, pins 0x12 and 0xB1 as
// fixed points of table one and writes the inverse tables. All table work runs
// through the single read and single write port of each RAM and the 15-step
// remainder unit: each swap draws a number, starts the remainder unit, waits
// for it, then does two reads and two writes. No item is accepted during init;
// configuration writes are.
`default_nettype none
`include "seeded_opcode_permutation_codec_macros.svh"
module seeded_opcode_permutation_codec import sopc_pkg::*; #(
	parameter int FIRST_TABLE_LAST = FIRST_TABLE_LAST_DEF,
	parameter int SECOND_TABLE_MAX = SECOND_TABLE_MAX_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [0:0]  cfg_index,
	input  wire logic [31:0] cfg_wdata,
	sopc_in_if.sink          cmd,
	sopc_out_if.source       rsp
);
	localparam int IW = $clog2(FIRST_TABLE_LAST + 1);
	localparam int AW = $clog2(SECOND_TABLE_MAX + 1);
	localparam logic [7:0] LAST8 = 8'(FIRST_TABLE_LAST);
	localparam logic [7:0] MAX8  = 8'(SECOND_TABLE_MAX);
	localparam logic [AW-1:0] TOP_RST = AW'((TOP_V0 > MAX8) ? MAX8 : TOP_V0);

	// Configuration registers
	logic [31:0] seed_q;
	logic [1:0]  version_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q    <= '0;
			version_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SEED:    seed_q    <= cfg_wdata;
				REG_VERSION: version_q <= cfg_wdata[1:0];
				default:     seed_q    <= seed_q;
			endcase
		end
	end

	// Sequencer state
	seq_state_t  state_q, state_d;
	logic [IW-1:0] i_q, i_d, j_q, j_d, k_q, k_d, ti_q, ti_d;
	logic        tsel_q, tsel_d, fsel_q, fsel_d;
	logic [31:0] g_q, g_d;
	logic        tables_ready_q, tables_ready_d;
	logic [AW-1:0] top2_q, top2_d;

	// Lookup stage and output register
	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [7:0]  b1_s1, b2_s1;
	logic        out_valid_q;
	logic [7:0]  first_out_q, second_out_q;
	logic [2:0]  status_q;

	// RAM ports
	logic          f1_we, f1_re, i1_we, i1_re, f2_we, f2_re, i2_we, i2_re;
	logic [IW-1:0] f1_waddr, f1_wdata, f1_raddr, f1_rdata;
	logic [IW-1:0] i1_waddr, i1_wdata, i1_raddr, i1_rdata;
	logic [AW-1:0] f2_waddr, f2_wdata, f2_raddr, f2_rdata;
	logic [AW-1:0] i2_waddr, i2_wdata, i2_raddr, i2_rdata;

	// Remainder unit
	logic          mod_start, mod_done;
	logic [IW-1:0] mod_rem;

	logic          s1_adv, accept, out_load_init;
	logic [7:0]    top_raw;
	logic [IW-1:0] sh_rdata, fix_v, shuffle_top;
	logic [31:0]   g_next;

	assign s1_adv    = valid_s1 && (!out_valid_q || rsp.ready);
	assign cmd.ready = (state_q == S_IDLE) && (!valid_s1 || s1_adv);
	assign accept    = cmd.valid && cmd.ready;
	assign g_next    = g_q * LCG_MUL + LCG_ADD;
	assign sh_rdata  = tsel_q ? IW'(f2_rdata) : f1_rdata;
	assign fix_v     = fsel_q ? IW'(FIX_B) : IW'(FIX_A);
	assign shuffle_top = tsel_q ? IW'(top2_q) : IW'(LAST8);

	// Second table top from the version register
	always_comb begin
		case (version_q)
			VER_1:   top_raw = TOP_V1;
			VER_2:   top_raw = TOP_V2;
			default: top_raw = TOP_V0;
		endcase
	end

	// Next state and RAM controls
	always_comb begin
		state_d        = state_q;
		i_d            = i_q;
		j_d            = j_q;
		k_d            = k_q;
		ti_d           = ti_q;
		tsel_d         = tsel_q;
		fsel_d         = fsel_q;
		g_d            = g_q;
		tables_ready_d = tables_ready_q;
		top2_d         = top2_q;
		mod_start      = 1'b0;
		out_load_init  = 1'b0;
		f1_we = 1'b0; f1_re = 1'b0; f1_waddr = '0; f1_wdata = '0; f1_raddr = '0;
		i1_we = 1'b0; i1_re = 1'b0; i1_waddr = '0; i1_wdata = '0; i1_raddr = '0;
		f2_we = 1'b0; f2_re = 1'b0; f2_waddr = '0; f2_wdata = '0; f2_raddr = '0;
		i2_we = 1'b0; i2_re = 1'b0; i2_waddr = '0; i2_wdata = '0; i2_raddr = '0;
		case (state_q)
			S_IDLE: begin
				// Issue lookups for a decode or encode item
				f1_raddr = IW'(cmd.first_byte);
				i1_raddr = IW'(cmd.first_byte);
				f2_raddr = AW'(cmd.second_byte);
				i2_raddr = AW'(cmd.second_byte);
				if (accept) begin
					if (cmd.op == OP_INIT) begin
						state_d = S_DRAIN;
					end else begin
						f1_re = 1'b1;
						i1_re = 1'b1;
						f2_re = 1'b1;
						i2_re = 1'b1;
					end
				end
			end
			S_DRAIN: begin
				// Wait for the lookup stage to empty, then seed
				if (!valid_s1) begin
					g_d     = seed_q;
					top2_d  = AW'((top_raw > MAX8) ? MAX8 : top_raw);
					i_d     = '0;
					state_d = S_FILL;
				end
			end
			S_FILL: begin
				// Write the identity into both forward tables
				f1_we    = 1'b1;
				f1_waddr = i_q;
				f1_wdata = i_q;
				if (i_q <= IW'(top2_q)) begin
					f2_we    = 1'b1;
					f2_waddr = AW'(i_q);
					f2_wdata = AW'(i_q);
				end
				if (i_q == IW'(LAST8)) begin
					i_d     = IW'(1);
					tsel_d  = 1'b0;
					state_d = S_RAND;
				end else begin
					i_d = i_q + IW'(1);
				end
			end
			S_RAND: begin
				g_d     = g_next;
				state_d = S_MOD_GO;
			end
			S_MOD_GO: begin
				mod_start = 1'b1;
				state_d   = S_MOD_WAIT;
			end
			S_MOD_WAIT: begin
				if (mod_done) begin
					j_d     = mod_rem;
					state_d = S_RD_I;
				end
			end
			S_RD_I: begin
				f1_re    = !tsel_q;
				f1_raddr = i_q;
				f2_re    = tsel_q;
				f2_raddr = AW'(i_q);
				state_d  = S_RD_J;
			end
			S_RD_J: begin
				// Capture entry i while entry j is read
				ti_d     = sh_rdata;
				f1_re    = !tsel_q;
				f1_raddr = j_q;
				f2_re    = tsel_q;
				f2_raddr = AW'(j_q);
				state_d  = S_WR_J;
			end
			S_WR_J: begin
				f1_we    = !tsel_q;
				f1_waddr = j_q;
				f1_wdata = ti_q;
				f2_we    = tsel_q;
				f2_waddr = AW'(j_q);
				f2_wdata = AW'(ti_q);
				state_d  = S_WR_I;
			end
			S_WR_I: begin
				// Entry j still sits on the read port
				f1_we    = !tsel_q;
				f1_waddr = i_q;
				f1_wdata = sh_rdata;
				f2_we    = tsel_q;
				f2_waddr = AW'(i_q);
				f2_wdata = AW'(sh_rdata);
				if (i_q == shuffle_top) begin
					if (!tsel_q) begin
						tsel_d  = 1'b1;
						i_d     = IW'(1);
						state_d = S_RAND;
					end else begin
						k_d     = '0;
						fsel_d  = 1'b0;
						state_d = S_SRCH_RD;
					end
				end else begin
					i_d     = i_q + IW'(1);
					state_d = S_RAND;
				end
			end
			S_SRCH_RD: begin
				f1_re    = 1'b1;
				f1_raddr = k_q;
				state_d  = S_SRCH_CMP;
			end
			S_SRCH_CMP: begin
				// Find the entry that holds the value to pin
				if (f1_rdata == fix_v) begin
					state_d = S_FIX_RD;
				end else if (k_q == IW'(LAST8)) begin
					fsel_d  = 1'b1;
					k_d     = '0;
					i_d     = '0;
					state_d = fsel_q ? S_INV_RD : S_SRCH_RD;
				end else begin
					k_d     = k_q + IW'(1);
					state_d = S_SRCH_RD;
				end
			end
			S_FIX_RD: begin
				f1_re    = 1'b1;
				f1_raddr = fix_v;
				state_d  = S_FIX_WK;
			end
			S_FIX_WK: begin
				f1_we    = 1'b1;
				f1_waddr = k_q;
				f1_wdata = f1_rdata;
				state_d  = S_FIX_WV;
			end
			S_FIX_WV: begin
				f1_we    = 1'b1;
				f1_waddr = fix_v;
				f1_wdata = fix_v;
				fsel_d   = 1'b1;
				k_d      = '0;
				i_d      = '0;
				state_d  = fsel_q ? S_INV_RD : S_SRCH_RD;
			end
			S_INV_RD: begin
				f1_re    = 1'b1;
				f1_raddr = i_q;
				f2_re    = (i_q <= IW'(top2_q));
				f2_raddr = AW'(i_q);
				state_d  = S_INV_WR;
			end
			S_INV_WR: begin
				// Scatter the index into the inverse tables
				i1_we    = 1'b1;
				i1_waddr = f1_rdata;
				i1_wdata = i_q;
				i2_we    = (i_q <= IW'(top2_q));
				i2_waddr = f2_rdata;
				i2_wdata = AW'(i_q);
				if (i_q == IW'(LAST8)) begin
					state_d = S_FINISH;
				end else begin
					i_d     = i_q + IW'(1);
					state_d = S_INV_RD;
				end
			end
			S_FINISH: begin
				if (!out_valid_q || rsp.ready) begin
					out_load_init  = 1'b1;
					tables_ready_d = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			tables_ready_q <= 1'b0;
			top2_q         <= TOP_RST;
			g_q            <= '0;
			tsel_q         <= 1'b0;
			fsel_q         <= 1'b0;
		end else begin
			state_q        <= state_d;
			tables_ready_q <= tables_ready_d;
			top2_q         <= top2_d;
			g_q            <= g_d;
			tsel_q         <= tsel_d;
			fsel_q         <= fsel_d;
		end
	end

	always_ff @(posedge clk) begin
		i_q  <= i_d;
		j_q  <= j_d;
		k_q  <= k_d;
		ti_q <= ti_d;
	end

	// Lookup stage: hold while the output register is full
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept && cmd.op != OP_INIT) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1 <= cmd.op;
			b1_s1 <= cmd.first_byte;
			b2_s1 <= cmd.second_byte;
		end
	end

	// Map the bytes from the table read data
	logic [7:0] res_first, res_second, plain;
	logic [2:0] res_status;
	logic       is_dec;

	always_comb begin
		is_dec     = (op_s1 == OP_DECODE);
		res_first  = b1_s1;
		res_second = b2_s1;
		res_status = ST_NONE;
		plain      = is_dec ? 8'(f1_rdata) : b1_s1;
		if ((op_s1 == OP_DECODE || op_s1 == OP_ENCODE) && tables_ready_q) begin
			if (b1_s1 > LAST8) begin
				res_status = ST_BAD_FIRST;
			end else begin
				res_first  = is_dec ? 8'(f1_rdata) : 8'(i1_rdata);
				res_status = ST_ONE;
				if (plain == EXT_MARK) begin
					if (b2_s1 > 8'(top2_q)) begin
						res_status = ST_BAD_SECOND;
					end else begin
						res_second = is_dec ? 8'(f2_rdata) : 8'(i2_rdata);
						res_status = ST_TWO;
					end
				end
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv || out_load_init) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load_init) begin
			first_out_q  <= '0;
			second_out_q <= '0;
			status_q     <= ST_INIT_DONE;
		end else if (s1_adv) begin
			first_out_q  <= res_first;
			second_out_q <= res_second;
			status_q     <= res_status;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.first_out  = first_out_q;
	assign rsp.second_out = second_out_q;
	assign rsp.status     = status_q;

	// Table memories
	sopc_ram #(.WIDTH(IW), .DEPTH(FIRST_TABLE_LAST + 1)) u_fwd_one (
		.clk(clk), .we(f1_we), .waddr(f1_waddr), .wdata(f1_wdata),
		.re(f1_re), .raddr(f1_raddr), .rdata(f1_rdata)
	);
	sopc_ram #(.WIDTH(IW), .DEPTH(FIRST_TABLE_LAST + 1)) u_inv_one (
		.clk(clk), .we(i1_we), .waddr(i1_waddr), .wdata(i1_wdata),
		.re(i1_re), .raddr(i1_raddr), .rdata(i1_rdata)
	);
	sopc_ram #(.WIDTH(AW), .DEPTH(SECOND_TABLE_MAX + 1)) u_fwd_two (
		.clk(clk), .we(f2_we), .waddr(f2_waddr), .wdata(f2_wdata),
		.re(f2_re), .raddr(f2_raddr), .rdata(f2_rdata)
	);
	sopc_ram #(.WIDTH(AW), .DEPTH(SECOND_TABLE_MAX + 1)) u_inv_two (
		.clk(clk), .we(i2_we), .waddr(i2_waddr), .wdata(i2_wdata),
		.re(i2_re), .raddr(i2_raddr), .rdata(i2_rdata)
	);

	// Swap index: rand mod (i + 1)
	sopc_modulo #(.IDXW(IW)) u_modulo (
		.clk(clk), .arst_n(arst_n), .start(mod_start),
		.dividend(g_q[16 +: RAND_W]),
		.divisor({1'b0, i_q} + (IW + 1)'(1)),
		.done(mod_done), .rem(mod_rem)
	);

	`SOPC_ASSERT_IMPL(a_ready_only_idle, cmd.ready, state_q == S_IDLE)
	`SOPC_ASSERT_IMPL(a_s1_no_seq, valid_s1, state_q == S_IDLE || state_q == S_DRAIN)
	`SOPC_ASSERT_IMPL(a_init_marks_ready, rsp.valid && rsp.status == ST_INIT_DONE,
		tables_ready_q)
	`SOPC_ASSERT_IMPL(a_unmapped_before_init, rsp.valid && !tables_ready_q,
		rsp.status == ST_NONE)
endmodule
`default_nettype wire
